@@ hdl/fft_pkg.sv @@
// shared types and constants for the frame filter and fragment tracker
// no dependencies; imported by fft_chan_table, fft_slot_store, the top level and the dv checker and testbench
`timescale 1ns / 1ps
`default_nettype none

package fft_pkg;

  localparam logic [15:0] CTRL_MASK  = 16'hFBFF;
  localparam logic [15:0] CTRL_DATA  = 16'h0208;
  localparam logic [31:0] ADDR_RESET = 32'hCCC28001;

  typedef enum logic [2:0] {
    MODE_FRAME = 3'd0,
    MODE_OPEN  = 3'd1,
    MODE_CLOSE = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_QUERY = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_NOSLOT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    COP_OPEN  = 2'd0,
    COP_CLOSE = 2'd1,
    COP_CLEAR = 2'd2,
    COP_FIND  = 2'd3
  } chan_op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] channel;
    logic [15:0] frame_control;
    logic [31:0] dest_word;
    logic [31:0] filter_word;
    logic [15:0] resp_chan;
    logic [31:0] message_id;
    logic [7:0]  fragment_total;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        message_done;
    logic [2:0]  slot_index;
    logic [31:0] done_id;
    logic [15:0] done_channel;
    logic [15:0] done_resp_chan;
    logic        is_open;
  } out_item_t;

  typedef struct packed {
    logic        req;
    chan_op_t    op;
    logic [15:0] ch;
  } chan_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
    logic full;
  } chan_rsp_t;

  typedef struct packed {
    logic        req;
    logic [31:0] id;
    logic [7:0]  total;
  } slot_cmd_t;

  typedef struct packed {
    logic       done;
    logic       nofree;
    logic       msg_done;
    logic [2:0] slot_index;
  } slot_rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  rcv;
  } slot_ent_t;

endpackage

`default_nettype wire

@@ hdl/fft_chan_table.sv @@
// ordered table of open channels in a one-port-read, one-port-write memory
// depends on fft_pkg
`timescale 1ns / 1ps
`default_nettype none

module fft_chan_table #(
  parameter int DEPTH = 128
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  fft_pkg::chan_cmd_t  cmd,
  output fft_pkg::chan_rsp_t  rsp
);
  import fft_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_SCAN  = 3'b010,
    CS_SHIFT = 3'b100
  } cstate_t;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  cstate_t     state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] tag_r, tag_nxt;
  logic [15:0] key_r, key_nxt;
  chan_op_t    op_r, op_nxt;
  chan_rsp_t   rsp_r, rsp_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          match;
  logic          last;

  assign rd_addr = iss_r[AW-1:0];
  assign match   = pend_r && (rd_data_r == key_r);
  assign last    = pend_r && ((CW'(tag_r) + CW'(1)) == cnt_r);
  assign rsp     = rsp_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    iss_nxt   = iss_r;
    pend_nxt  = pend_r;
    tag_nxt   = tag_r;
    key_nxt   = key_r;
    op_nxt    = op_r;
    rsp_nxt   = '0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = cmd.ch;
    unique case (state_r)
      CS_IDLE: begin
        if (cmd.req) begin
          key_nxt = cmd.ch;
          op_nxt  = cmd.op;
          unique case (cmd.op)
            COP_OPEN: begin
              rsp_nxt.done = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                rsp_nxt.full = 1'b1;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            COP_CLEAR: begin
              rsp_nxt.done = 1'b1;
              cnt_nxt      = '0;
            end
            default: begin
              if (cnt_r == '0) begin
                rsp_nxt.done = 1'b1;
              end else begin
                state_nxt = CS_SCAN;
                iss_nxt   = '0;
                pend_nxt  = 1'b0;
              end
            end
          endcase
        end
      end
      CS_SCAN: begin
        rd_en    = iss_r < cnt_r;
        iss_nxt  = rd_en ? iss_r + CW'(1) : iss_r;
        pend_nxt = rd_en;
        tag_nxt  = iss_r[AW-1:0];
        if (match) begin
          if (op_r == COP_CLOSE && !last) begin
            // close the gap from the entry after the match
            state_nxt = CS_SHIFT;
            iss_nxt   = CW'(tag_r) + CW'(1);
            pend_nxt  = 1'b0;
          end else begin
            if (op_r == COP_CLOSE) begin
              cnt_nxt = cnt_r - CW'(1);
            end
            state_nxt     = CS_IDLE;
            rsp_nxt.done  = 1'b1;
            rsp_nxt.found = 1'b1;
          end
        end else if (last) begin
          state_nxt    = CS_IDLE;
          rsp_nxt.done = 1'b1;
        end
      end
      CS_SHIFT: begin
        rd_en    = iss_r < cnt_r;
        iss_nxt  = rd_en ? iss_r + CW'(1) : iss_r;
        pend_nxt = rd_en;
        tag_nxt  = iss_r[AW-1:0];
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = tag_r - AW'(1);
          wr_data = rd_data_r;
        end
        if (last) begin
          cnt_nxt       = cnt_r - CW'(1);
          state_nxt     = CS_IDLE;
          rsp_nxt.done  = 1'b1;
          rsp_nxt.found = 1'b1;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      rsp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      rsp_r   <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r <= iss_nxt;
    tag_r <= tag_nxt;
    key_r <= key_nxt;
    op_r  <= op_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/fft_slot_store.sv @@
// reassembly slots: ids and fragment counts in memory, valid bits in flops
// depends on fft_pkg
`timescale 1ns / 1ps
`default_nettype none

module fft_slot_store #(
  parameter int SLOT_COUNT = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  fft_pkg::slot_cmd_t  cmd,
  output fft_pkg::slot_rsp_t  rsp
);
  import fft_pkg::*;

  localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    SS_IDLE = 2'b01,
    SS_SCAN = 2'b10
  } sstate_t;

  slot_ent_t mem [SLOT_COUNT];
  slot_ent_t rd_data_r;

  sstate_t          state_r, state_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [SCW-1:0]   iss_r, iss_nxt;
  logic             pend_r, pend_nxt;
  logic [SW-1:0]    tag_r, tag_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [7:0]       total_r, total_nxt;
  logic             ffound_r, ffound_nxt;
  logic [SW-1:0]    free_r, free_nxt;
  slot_rsp_t        rsp_r, rsp_nxt;

  logic          rd_en;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  slot_ent_t     wr_data;
  logic          hit;
  logic          last;
  logic          cur_free;
  logic [7:0]    new_rcv;
  logic [SW-1:0] free_sel;

  assign hit      = pend_r && valid_r[tag_r] && (rd_data_r.id == key_r);
  assign last     = pend_r && ((SCW'(tag_r) + SCW'(1)) == SCW'(SLOT_COUNT));
  assign cur_free = pend_r && !valid_r[tag_r];
  assign new_rcv  = rd_data_r.rcv + 8'd1;
  assign free_sel = ffound_r ? free_r : tag_r;
  assign rsp      = rsp_r;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    iss_nxt    = iss_r;
    pend_nxt   = pend_r;
    tag_nxt    = tag_r;
    key_nxt    = key_r;
    total_nxt  = total_r;
    ffound_nxt = ffound_r;
    free_nxt   = free_r;
    rsp_nxt    = '0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = tag_r;
    wr_data    = '{id: key_r, rcv: new_rcv};
    unique case (state_r)
      SS_IDLE: begin
        if (cmd.req) begin
          key_nxt    = cmd.id;
          total_nxt  = cmd.total;
          iss_nxt    = '0;
          pend_nxt   = 1'b0;
          ffound_nxt = 1'b0;
          state_nxt  = SS_SCAN;
        end
      end
      SS_SCAN: begin
        rd_en    = iss_r < SCW'(SLOT_COUNT);
        iss_nxt  = rd_en ? iss_r + SCW'(1) : iss_r;
        pend_nxt = rd_en;
        tag_nxt  = iss_r[SW-1:0];
        if (hit) begin
          // lowest matching slot wins; count wraps at 8 bits
          wr_en              = 1'b1;
          rsp_nxt.done       = 1'b1;
          rsp_nxt.slot_index = 3'(tag_r);
          if (new_rcv == total_r) begin
            valid_nxt[tag_r]  = 1'b0;
            rsp_nxt.msg_done  = 1'b1;
          end
          state_nxt = SS_IDLE;
        end else begin
          if (cur_free && !ffound_r) begin
            ffound_nxt = 1'b1;
            free_nxt   = tag_r;
          end
          if (last) begin
            rsp_nxt.done = 1'b1;
            state_nxt    = SS_IDLE;
            if (ffound_r || cur_free) begin
              wr_en              = 1'b1;
              wr_addr            = free_sel;
              wr_data            = '{id: key_r, rcv: 8'd1};
              valid_nxt[free_sel] = 1'b1;
              rsp_nxt.slot_index = 3'(free_sel);
            end else begin
              rsp_nxt.nofree = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = SS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
      valid_r <= '0;
      pend_r  <= 1'b0;
      rsp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      rsp_r   <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r    <= iss_nxt;
    tag_r    <= tag_nxt;
    key_r    <= key_nxt;
    total_r  <= total_nxt;
    ffound_r <= ffound_nxt;
    free_r   <= free_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/frame_filter_fragment_tracker_unit.sv @@
// top level of the frame filter and fragment tracker
// depends on fft_pkg, fft_chan_table and fft_slot_store
//
// usage:
//   in_valid/in_stall carry one request item (in_data); mode picks frame,
//   open, close, close-all or query. out_valid/out_stall return exactly one
//   result item (out_data) per request, in order.
//   cfg_wr_en/cfg_wr_data write the match address at any idle moment.
// processing:
//   one item at a time. open, close-all and any walk of an empty table end
//   without a table read; filtered-out frames and unknown modes skip the
//   table. query and frame filtering walk the open channel table one entry
//   a cycle through a pipelined memory read. close goes on from the match,
//   moving the entries behind it down by one. a fragmented frame then walks
//   the SLOT_COUNT reassembly slots until it finds its message id or, if
//   no slot holds it, through all of them.
// reset:
//   synchronous, active low; empties the channel table and frees all slots,
//   match address returns to its default. memories need no clearing pass.
// back-pressure:
//   a finished result sits in the output register; the next item is taken
//   while it waits, and only a second finished result waits on out_stall
`timescale 1ns / 1ps
`default_nettype none

module frame_filter_fragment_tracker_unit #(
  parameter int CHANNEL_DEPTH = 128,
  parameter int SLOT_COUNT    = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  fft_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output fft_pkg::out_item_t  out_data,
  input  wire                 cfg_wr_en,
  input  wire  [31:0]         cfg_wr_data
);
  import fft_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CHAN = 4'b0010,
    ST_SLOT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  in_item_t    item_r, item_nxt;
  out_item_t   res_r, res_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] match_addr_r;

  chan_cmd_t chan_cmd;
  chan_rsp_t chan_rsp;
  slot_cmd_t slot_cmd;
  slot_rsp_t slot_rsp;

  logic accept;
  logic filt_ok;
  logic fin_load;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // address and control filter, checked on the incoming item
  assign filt_ok = ((in_data.frame_control & CTRL_MASK) == CTRL_DATA) &&
                   (in_data.dest_word == match_addr_r) &&
                   (in_data.filter_word == match_addr_r);

  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    chan_cmd  = '{req: 1'b0, op: COP_FIND, ch: in_data.channel};
    slot_cmd  = '{req: 1'b0, id: item_r.message_id, total: item_r.fragment_total};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          state_nxt = ST_CHAN;
          unique case (in_data.mode)
            MODE_FRAME: begin
              if (filt_ok) begin
                chan_cmd.req = 1'b1;
              end else begin
                res_nxt.status = STAT_REJECT;
                state_nxt      = ST_FIN;
              end
            end
            MODE_OPEN: begin
              chan_cmd.req = 1'b1;
              chan_cmd.op  = COP_OPEN;
            end
            MODE_CLOSE: begin
              chan_cmd.req = 1'b1;
              chan_cmd.op  = COP_CLOSE;
            end
            MODE_CLEAR: begin
              chan_cmd.req = 1'b1;
              chan_cmd.op  = COP_CLEAR;
            end
            MODE_QUERY: begin
              chan_cmd.req = 1'b1;
            end
            default: begin
              // unknown mode: all-zero result
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_CHAN: begin
        if (chan_rsp.done) begin
          state_nxt = ST_FIN;
          unique case (item_r.mode)
            MODE_FRAME: begin
              if (!chan_rsp.found) begin
                res_nxt.status = STAT_REJECT;
              end else begin
                res_nxt.done_id        = item_r.message_id;
                res_nxt.done_channel   = item_r.channel;
                res_nxt.done_resp_chan = item_r.resp_chan;
                if (item_r.fragment_total == 8'd1) begin
                  // single fragment completes without a slot
                  res_nxt.message_done = 1'b1;
                end else begin
                  slot_cmd.req = 1'b1;
                  state_nxt    = ST_SLOT;
                end
              end
            end
            MODE_OPEN: begin
              if (chan_rsp.full) begin
                res_nxt.status = STAT_FULL;
              end
            end
            MODE_QUERY: begin
              res_nxt.is_open = chan_rsp.found;
            end
            default: begin
              res_nxt.status = STAT_OK;
            end
          endcase
        end
      end
      ST_SLOT: begin
        if (slot_rsp.done) begin
          state_nxt = ST_FIN;
          if (slot_rsp.nofree) begin
            res_nxt.status = STAT_NOSLOT;
          end else begin
            res_nxt.slot_index   = slot_rsp.slot_index;
            res_nxt.message_done = slot_rsp.msg_done;
          end
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register: loads from the finished result, empties when taken
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (fin_load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  fft_chan_table #(
    .DEPTH (CHANNEL_DEPTH)
  ) u_chan (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (chan_cmd),
    .rsp   (chan_rsp)
  );

  fft_slot_store #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (slot_cmd),
    .rsp   (slot_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      match_addr_r <= ADDR_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        match_addr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted item did not start processing");

  // table answers only arrive while waiting for them
  a_chan_rsp_state: assert property (@(posedge clk) disable iff (!rst_n)
    chan_rsp.done |-> state_r == ST_CHAN)
    else $error("channel table response outside wait state");

  // slot answers only arrive while waiting for them
  a_slot_rsp_state: assert property (@(posedge clk) disable iff (!rst_n)
    slot_rsp.done |-> state_r == ST_SLOT)
    else $error("slot store response outside wait state");

  // a completed message is never reported with an error status
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.message_done |-> out_data.status == STAT_OK)
    else $error("message done with non-ok status");

endmodule

`default_nettype wire

@@ dv/fft_tracker_checker.sv @@
// result checker for the frame filter and fragment tracker: watches both channels,
// predicts each result and compares it field by field. depends on hdl/fft_pkg.sv
`timescale 1ns / 1ps

module fft_tracker_checker #(
  parameter int CHANNEL_DEPTH = 128,
  parameter int SLOT_COUNT    = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  fft_pkg::in_item_t   in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  fft_pkg::out_item_t  out_data,
  input  wire                 cfg_wr_en,
  input  wire  [31:0]         cfg_wr_data,
  output int                  fail_count,
  output int                  pending_count
);
  import fft_pkg::*;

  // own copy of the block state
  logic [31:0] match_addr;
  logic [15:0] open_chans[$];
  logic        slot_busy[SLOT_COUNT];
  logic [31:0] slot_msg[SLOT_COUNT];
  logic [7:0]  slot_seen[SLOT_COUNT];

  out_item_t   awaited_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic bit chan_listed(input logic [15:0] ch);
    bit hit;
    hit = 1'b0;
    foreach (open_chans[i])
      if (open_chans[i] == ch) hit = 1'b1;
    return hit;
  endfunction

  // one item in, one result out; updates the channel list and slots
  function automatic out_item_t filter_and_track(input in_item_t it);
    out_item_t r;
    bit        placed;
    int        close_at;
    r = '0;
    case (it.mode)
      MODE_FRAME: begin
        if ((it.frame_control & CTRL_MASK) != CTRL_DATA || it.dest_word != match_addr ||
            it.filter_word != match_addr || !chan_listed(it.channel)) begin
          r.status = STAT_REJECT;
        end else begin
          r.done_id        = it.message_id;
          r.done_channel   = it.channel;
          r.done_resp_chan = it.resp_chan;
          if (it.fragment_total == 8'd1) begin
            r.message_done = 1'b1;
          end else begin
            placed = 1'b0;
            // lowest live slot holding this id wins
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (!placed && slot_busy[s] && slot_msg[s] == it.message_id) begin
                placed       = 1'b1;
                slot_seen[s] = slot_seen[s] + 8'd1;
                r.slot_index = s[2:0];
                if (slot_seen[s] == it.fragment_total) begin
                  slot_busy[s]   = 1'b0;
                  r.message_done = 1'b1;
                end
              end
            end
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (!placed && !slot_busy[s]) begin
                placed       = 1'b1;
                slot_busy[s] = 1'b1;
                slot_msg[s]  = it.message_id;
                slot_seen[s] = 8'd1;
                r.slot_index = s[2:0];
              end
            end
            if (!placed) r.status = STAT_NOSLOT;
          end
        end
      end
      MODE_OPEN: begin
        if (open_chans.size() >= CHANNEL_DEPTH) r.status = STAT_FULL;
        else open_chans.push_back(it.channel);
      end
      MODE_CLOSE: begin
        close_at = -1;
        foreach (open_chans[i])
          if (close_at < 0 && open_chans[i] == it.channel) close_at = i;
        if (close_at >= 0) open_chans.delete(close_at);
      end
      MODE_CLEAR: open_chans.delete();
      MODE_QUERY: r.is_open = chan_listed(it.channel);
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      match_addr = ADDR_RESET;
      open_chans.delete();
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) match_addr = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result 0x%0h with no item outstanding", out_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("message_done", 32'(want.message_done),
                      32'(out_data.message_done));
          check_field("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
          check_field("done_id", want.done_id, out_data.done_id);
          check_field("done_channel", 32'(want.done_channel),
                      32'(out_data.done_channel));
          check_field("done_resp_chan", 32'(want.done_resp_chan),
                      32'(out_data.done_resp_chan));
          check_field("is_open", 32'(want.is_open), 32'(out_data.is_open));
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(filter_and_track(in_data));
    end
    pending_count = awaited_results.size();
  end

endmodule

@@ dv/frame_filter_fragment_tracker_unit_tb.sv @@
// testbench top for frame_filter_fragment_tracker_unit: directed and random items,
// idle and stall phases, address changes. depends on hdl/fft_pkg.sv, the block and
// dv/fft_tracker_checker.sv
`timescale 1ns / 1ps

module frame_filter_fragment_tracker_unit_tb;
  import fft_pkg::*;

  localparam int CHANNEL_DEPTH = 128;
  localparam int SLOT_COUNT    = 8;
  localparam int ITEM_TARGET   = 1050;
  localparam int HOLD_CYCLES   = 600;      // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;        // quiet gap before an address write
  localparam int END_CYCLES    = 200;      // beyond the slowest frame walk
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  in_item_t    in_data     = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  int          fail_count;
  int          pending_count;

  // stimulus knobs, percentages per cycle
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  logic [31:0] cur_addr = ADDR_RESET;      // address that good frames carry
  logic [15:0] busy_ch;                    // channel open for the current messages
  logic [15:0] chan_pool[16];              // channels that noise opens and closes

  // long hold-off request: the receiver process notices the toggle
  bit          hold_req  = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;

  frame_filter_fragment_tracker_unit #(
    .CHANNEL_DEPTH (CHANNEL_DEPTH),
    .SLOT_COUNT    (SLOT_COUNT)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fft_tracker_checker #(
    .CHANNEL_DEPTH (CHANNEL_DEPTH),
    .SLOT_COUNT    (SLOT_COUNT)
  ) track_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("frame_filter_fragment_tracker_unit_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  // every field random, mode as given
  function automatic in_item_t random_item(input logic [2:0] mode);
    in_item_t it;
    it.mode           = mode;
    it.channel        = 16'($urandom);
    it.frame_control  = 16'($urandom);
    it.dest_word      = $urandom;
    it.filter_word    = $urandom;
    it.resp_chan      = 16'($urandom);
    it.message_id     = $urandom;
    it.fragment_total = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t chan_item(input logic [2:0] mode, input logic [15:0] ch);
    in_item_t it;
    it         = random_item(mode);
    it.channel = ch;
    return it;
  endfunction

  // a frame that passes the filter if ch is open; the masked-off control bit is random
  function automatic in_item_t good_frame(input logic [15:0] ch, input logic [31:0] id,
                                          input logic [7:0] total);
    in_item_t it;
    it                = random_item(MODE_FRAME);
    it.channel        = ch;
    it.frame_control  = CTRL_DATA | (~CTRL_MASK & 16'($urandom));
    it.dest_word      = cur_addr;
    it.filter_word    = cur_addr;
    it.message_id     = id;
    it.fragment_total = total;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at a falling edge once the item is taken
  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // wait until every result has come back, then a short quiet gap
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // address change only with the block idle
  task automatic write_address(input logic [31:0] addr);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    cur_addr     = addr;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus pieces
  // ---------------------------------------------------------------------------

  // filler between fragments: rejected frames, single fragments, table traffic,
  // queries and unused modes; never leaves a slot behind
  task automatic send_noise;
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      it = good_frame(chan_pool[$urandom_range(15)], $urandom, 8'($urandom));
      case ($urandom_range(3))
        0: begin
          it.frame_control = 16'($urandom);
          if ((it.frame_control & CTRL_MASK) == CTRL_DATA) it.frame_control ^= 16'h0001;
        end
        1: it.dest_word   = cur_addr ^ (32'h1 << $urandom_range(31));
        2: it.filter_word = cur_addr ^ (32'h1 << $urandom_range(31));
        default: begin
          // channel most likely not open; single fragment in case it is
          it.channel        = 16'($urandom);
          it.fragment_total = 8'd1;
        end
      endcase
    end else if (pick < 40) begin
      it = good_frame(busy_ch, $urandom, 8'd1);
    end else if (pick < 52) begin
      it = chan_item(MODE_OPEN, chan_pool[$urandom_range(15)]);
    end else if (pick < 64) begin
      it = chan_item(MODE_CLOSE, chan_pool[$urandom_range(15)]);
    end else if (pick < 72) begin
      it = chan_item(MODE_QUERY, chan_pool[$urandom_range(15)]);
    end else if (pick < 80) begin
      it = chan_item(MODE_QUERY, busy_ch);
    end else if (pick < 90) begin
      it = random_item(3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)));
    end else begin
      it = random_item(MODE_QUERY);
    end
    push_item(it);
  endtask

  // one to four interleaved messages on a freshly opened channel, noise between
  task automatic run_group;
    logic [31:0] ids[4];
    logic [7:0]  totals[4];
    int          left[4];
    int          n;
    int          k;
    int          busy;
    n       = $urandom_range(4, 1);
    busy_ch = ($urandom_range(3) == 0) ? chan_pool[$urandom_range(15)] : 16'($urandom);
    push_item(chan_item(MODE_OPEN, busy_ch));
    for (k = 0; k < n; k++) begin
      ids[k]    = $urandom;
      totals[k] = ($urandom_range(7) == 0) ? 8'd1 : 8'($urandom_range(6, 2));
      left[k]   = int'(totals[k]);
    end
    // extreme ids now and then; only the first message, so ids stay distinct
    case ($urandom_range(19))
      0: ids[0] = 32'h0000_0000;
      1: ids[0] = 32'hFFFF_FFFF;
      default: ;
    endcase
    busy = n;
    while (busy > 0) begin
      if ($urandom_range(3) == 0) begin
        send_noise();
      end else begin
        k = $urandom_range(n - 1);
        while (left[k] == 0) k = (k + 1) % n;
        push_item(good_frame(busy_ch, ids[k], totals[k]));
        left[k]--;
        if (left[k] == 0) busy--;
      end
    end
    push_item(chan_item(MODE_CLOSE, busy_ch));
    if ($urandom_range(6) == 0) push_item(random_item(MODE_CLEAR));
  endtask

  // fill every slot, knock on a full store, then finish the messages
  task automatic overflow_slots;
    logic [31:0] ids[SLOT_COUNT];
    logic [7:0]  totals[SLOT_COUNT];
    busy_ch = 16'($urandom);
    push_item(chan_item(MODE_OPEN, busy_ch));
    for (int k = 0; k < SLOT_COUNT; k++) begin
      ids[k]    = $urandom;
      totals[k] = 8'($urandom_range(4, 2));
      push_item(good_frame(busy_ch, ids[k], totals[k]));
    end
    // no free slot: dropped, never counted anywhere
    repeat (3) push_item(good_frame(busy_ch, $urandom, 8'($urandom_range(4, 2))));
    for (int k = SLOT_COUNT - 1; k >= 0; k--)
      for (int f = 1; f < totals[k]; f++)
        push_item(good_frame(busy_ch, ids[k], totals[k]));
    push_item(chan_item(MODE_CLOSE, busy_ch));
  endtask

  // fill the channel table while the receiver holds off, so the block backs up
  task automatic fill_table;
    logic [15:0] filled[CHANNEL_DEPTH];
    push_item(random_item(MODE_CLEAR));
    hold_req = ~hold_req;
    for (int k = 0; k < CHANNEL_DEPTH; k++) begin
      // some duplicates along the way
      filled[k] = (k > 0 && $urandom_range(9) == 0) ? filled[k - 1] : 16'($urandom);
      push_item(chan_item(MODE_OPEN, filled[k]));
    end
    push_item(chan_item(MODE_OPEN, 16'($urandom)));             // table full
    push_item(chan_item(MODE_QUERY, filled[CHANNEL_DEPTH - 1]));
    push_item(good_frame(filled[CHANNEL_DEPTH - 1], $urandom, 8'd1));
    push_item(chan_item(MODE_CLOSE, filled[CHANNEL_DEPTH / 2]));
    push_item(chan_item(MODE_QUERY, filled[CHANNEL_DEPTH - 1]));
    push_item(random_item(MODE_CLEAR));
  endtask

  // zero fragment total: slot only completes when its count wraps round
  task automatic wrap_count;
    logic [31:0] id;
    id      = $urandom;
    busy_ch = 16'($urandom);
    push_item(chan_item(MODE_OPEN, busy_ch));
    repeat (256) push_item(good_frame(busy_ch, id, 8'd0));
    push_item(chan_item(MODE_CLOSE, busy_ch));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_item_t    it;
    logic [31:0] phase_addr[4];
    int          phase_idle[4];
    int          phase_stall[4];

    phase_addr  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0, ADDR_RESET};
    phase_addr[2] = $urandom;
    phase_idle  = '{0, 56, 0, 12};
    phase_stall = '{0, 0, 56, 12};

    chan_pool[0] = 16'h0000;
    chan_pool[1] = 16'hFFFF;
    for (int k = 2; k < 16; k++) chan_pool[k] = 16'($urandom);
    busy_ch = chan_pool[0];

    // synchronous reset
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset address
    push_item(chan_item(MODE_QUERY, 16'h0000));                 // empty table
    push_item(good_frame(16'h0000, 32'h1, 8'd1));               // channel not open
    push_item(chan_item(MODE_CLOSE, 16'h7777));                 // close of absent channel
    push_item(chan_item(MODE_OPEN, 16'h0000));
    push_item(chan_item(MODE_OPEN, 16'hFFFF));
    push_item(chan_item(MODE_OPEN, 16'h1234));
    push_item(chan_item(MODE_OPEN, 16'h1234));                  // duplicate open
    push_item(chan_item(MODE_QUERY, 16'hFFFF));
    push_item(chan_item(MODE_CLOSE, 16'h1234));                 // first copy only
    push_item(chan_item(MODE_QUERY, 16'h1234));
    push_item(chan_item(MODE_CLOSE, 16'h1234));
    push_item(chan_item(MODE_QUERY, 16'h1234));
    it = good_frame(16'hFFFF, 32'hFFFF_FFFF, 8'd1);             // single fragment
    it.resp_chan = 16'hFFFF;
    push_item(it);
    it = good_frame(16'h0000, 32'h0, 8'd2);                     // new message, slot taken
    it.frame_control = CTRL_DATA | ~CTRL_MASK;
    it.resp_chan = 16'h0000;
    push_item(it);
    push_item(good_frame(16'h0000, 32'h0, 8'd2));               // completes, slot freed
    it = good_frame(16'hFFFF, 32'h5, 8'd1);
    it.frame_control = CTRL_DATA ^ 16'h0001;                    // bad control word
    push_item(it);
    it = good_frame(16'hFFFF, 32'h5, 8'd1);
    it.dest_word = ~cur_addr;                                   // bad destination
    push_item(it);
    it = good_frame(16'hFFFF, 32'h5, 8'd1);
    it.filter_word = ~cur_addr;                                 // bad filter word
    push_item(it);
    push_item(good_frame(16'h1234, 32'h5, 8'd1));               // closed channel
    push_item(random_item(3'd5));
    push_item(random_item(3'd6));
    push_item(random_item(MODE_UNUSED_HI));
    push_item(random_item(MODE_CLEAR));
    push_item(chan_item(MODE_QUERY, 16'hFFFF));

    // random phases, each with its own address and idle pattern; each phase
    // starts from a drained block, which also covers the full pause
    for (int p = 0; p < 4; p++) begin
      write_address(phase_addr[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      case (p)
        0: overflow_slots();
        1: fill_table();
        2: wrap_count();
        default: overflow_slots();
      endcase
      while (items_sent < (p + 1) * ITEM_TARGET / 4) run_group();
    end

    drain();
    repeat (END_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("frame_filter_fragment_tracker_unit_tb: PASS");
    else
      $display("frame_filter_fragment_tracker_unit_tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fft_pkg.sv
hdl/fft_chan_table.sv
hdl/fft_slot_store.sv
hdl/frame_filter_fragment_tracker_unit.sv
dv/fft_tracker_checker.sv
dv/frame_filter_fragment_tracker_unit_tb.sv
